/* hw/rtl/pcm_sample_player_resampler_top_defines.svh */
// assertion macros used by the player sequencer
`ifndef PCM_SAMPLE_PLAYER_RESAMPLER_TOP_DEFINES_SVH
`define PCM_SAMPLE_PLAYER_RESAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, skipped while reset is asserted
`define PSPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pspr assertion failed");
// checked property, also evaluated during reset
`define PSPR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pspr reset assertion failed");
`else
`define PSPR_ASSERT(lbl, clk, rst_n, prop)
`define PSPR_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* hw/rtl/pspr_pkg.sv */
package pspr_pkg;

    // fixed field widths and number formats
    localparam int POS_BITS   = 28;
    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = POS_BITS - FRAC_BITS;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int STEP_W     = 24;
    localparam int FCNT_W     = 13;
    localparam int CHCNT_W    = 2;
    localparam int FRAME_W    = 12;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_FRAMES_DEF   = 4096;
    localparam int MAX_CHANNELS_DEF = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRODUCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEEK    = 2'd2;

    // play status codes
    localparam logic [STATUS_W-1:0] ST_PLAYING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MUTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENDED   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHCNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FCNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LGAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RGAIN  = 3'd6;

    // reset values
    localparam logic [CHCNT_W-1:0] RST_CHCNT = 2'd2;
    localparam logic [FCNT_W-1:0]  RST_FCNT  = 13'd4096;
    localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    typedef struct packed {
        logic                loop_en;
        logic                stereo;
        logic [FCNT_W-1:0]   last_frame;
        logic                pitch_unity;
        logic [STEP_W-1:0]   pitch_step;
        logic [GAIN_W-1:0]   master_gain;
        logic [GAIN_W-1:0]   left_gain;
        logic [GAIN_W-1:0]   right_gain;
    } cfg_t;

    typedef struct packed {
        logic mute;
        logic at_end;
        logic loop_en;
        logic stereo;
    } sts_t;

    typedef struct packed {
        logic                load_we;
        logic                seek;
        logic                res_clear;
        logic                mod_start;
        logic                mod_step;
        logic                mod_wb;
        logic                rd_hi;
        logic                lo_cap;
        logic                interp;
        logic                scale;
        logic                sat;
        logic                out_load;
        logic                advance;
        logic                chan;
        logic [STATUS_W-1:0] status;
    } cmd_t;

endpackage

/* hw/rtl/pcm_sample_player_resampler_top.sv */
// channel   direction  handshake                 payload
// s_        in         s_valid / s_ready         kind, load frame/channel/value, seek position
// m_        out        m_valid / m_ready         left, right, play status
// cfg_      in         cfg_we (no wait)          register index, write data
//
// load and seek items leave the input ready again right after transfer; a produce
// item holds it off until its frame is written, running through one clip memory
// read port and five sequencer steps per channel (none when muted or ended)
// a wrap at the clip end adds a remainder loop, one remainder bit per cycle plus write-back
// the final step stalls while the output register still holds an untaken frame
// reset is synchronous active low: position zero, registers at defaults, output empty
module pcm_sample_player_resampler_top import pspr_pkg::*; #(
    parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    // configuration writes
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,

    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic [FRAME_W-1:0]         s_load_frame,
    input  logic                       s_load_channel,
    input  logic signed [SAMPLE_W-1:0] s_load_value,
    input  logic [POS_BITS-1:0]        s_seek_position,

    // output frames
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_left,
    output logic signed [SAMPLE_W-1:0] m_out_right,
    output logic [STATUS_W-1:0]        m_play_status
);

    cfg_t cfg;   // decoded register values, frame count already clamped
    sts_t sts;   // datapath flags the sequencer branches on
    cmd_t cmd;   // per-cycle datapath controls

    // register file plus clamping of channel and frame counts
    pspr_cfg #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer: one item at a time, owns both handshakes
    pspr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // clip memory, play position, remainder unit, interpolation and gain path
    pspr_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .s_load_frame    (s_load_frame),
        .s_load_channel  (s_load_channel),
        .s_load_value    (s_load_value),
        .s_seek_position (s_seek_position),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_play_status   (m_play_status)
    );

endmodule

/* hw/rtl/pspr_cfg.sv */
module pspr_cfg import pspr_pkg::*; #(
    parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic                loop_en_reg;
    logic [CHCNT_W-1:0]  chcnt_reg;
    logic [FCNT_W-1:0]   fcnt_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [GAIN_W-1:0]   master_reg;
    logic [GAIN_W-1:0]   lgain_reg;
    logic [GAIN_W-1:0]   rgain_reg;
    logic [FCNT_W-1:0]   frames;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_en_reg <= 1'b0;
            chcnt_reg   <= RST_CHCNT;
            fcnt_reg    <= RST_FCNT;
            step_reg    <= STEP_ONE;
            master_reg  <= GAIN_ONE;
            lgain_reg   <= GAIN_ONE;
            rgain_reg   <= GAIN_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOOP:   loop_en_reg <= cfg_wdata[0];
                CFG_CHCNT:  chcnt_reg   <= cfg_wdata[CHCNT_W-1:0];
                CFG_FCNT:   fcnt_reg    <= cfg_wdata[FCNT_W-1:0];
                CFG_STEP:   step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_MASTER: master_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_LGAIN:  lgain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_RGAIN:  rgain_reg   <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp frame count to the memory size, at least two frames
    always_comb begin
        frames = fcnt_reg;
        if (fcnt_reg < FCNT_W'(2)) begin
            frames = FCNT_W'(2);
        end else if (32'(fcnt_reg) > MAX_FRAMES) begin
            frames = FCNT_W'(MAX_FRAMES);
        end
    end

    assign cfg.loop_en     = loop_en_reg;
    assign cfg.stereo      = (chcnt_reg >= CHCNT_W'(2)) && (MAX_CHANNELS > 1);
    assign cfg.last_frame  = frames - FCNT_W'(1);
    assign cfg.pitch_unity = (step_reg == STEP_ONE);
    assign cfg.pitch_step  = step_reg;
    assign cfg.master_gain = master_reg;
    assign cfg.left_gain   = lgain_reg;
    assign cfg.right_gain  = rgain_reg;

endmodule

/* hw/rtl/pspr_ctrl.sv */
`include "pcm_sample_player_resampler_top_defines.svh"

module pspr_ctrl import pspr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    output logic              m_valid,
    input  logic              m_ready,
    input  sts_t              sts,
    output cmd_t              cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;
    localparam logic [3:0] S_MODWB  = 4'd2;
    localparam logic [3:0] S_RDLO   = 4'd3;
    localparam logic [3:0] S_RDHI   = 4'd4;
    localparam logic [3:0] S_INTERP = 4'd5;
    localparam logic [3:0] S_SCALE  = 4'd6;
    localparam logic [3:0] S_SAT    = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;

    localparam int CNT_W = $clog2(INT_BITS);

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chan_reg, chan_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        chan_next    = chan_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.chan     = chan_reg;
        cmd.status   = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_LOAD: cmd.load_we = 1'b1;
                        KIND_SEEK: cmd.seek = 1'b1;
                        KIND_PRODUCE: begin
                            cmd.res_clear = 1'b1;
                            chan_next     = 1'b0;
                            status_next   = ST_PLAYING;
                            if (sts.mute) begin
                                status_next = ST_MUTED;
                                state_next  = S_WRITE;
                            end else if (sts.at_end && !sts.loop_en) begin
                                status_next = ST_ENDED;
                                state_next  = S_WRITE;
                            end else if (sts.at_end) begin
                                cmd.mod_start = 1'b1;
                                cnt_next      = '0;
                                state_next    = S_MOD;
                            end else begin
                                state_next = S_RDLO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(INT_BITS - 1)) begin
                    state_next = S_MODWB;
                end
            end
            S_MODWB: begin
                cmd.mod_wb = 1'b1;
                state_next = S_RDLO;
            end
            S_RDLO: begin
                state_next = S_RDHI;
            end
            S_RDHI: begin
                cmd.rd_hi  = 1'b1;
                cmd.lo_cap = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP: begin
                cmd.interp = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat = 1'b1;
                if (!chan_reg && sts.stereo) begin
                    chan_next  = 1'b1;
                    state_next = S_RDLO;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.advance  = (status_reg == ST_PLAYING);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            chan_reg    <= 1'b0;
            status_reg  <= ST_PLAYING;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chan_reg    <= chan_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a finished frame never overwrites one still waiting at the output
    `PSPR_ASSERT(a_out_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready))
    // a produce item holds off the input until its frame is written
    `PSPR_ASSERT(a_produce_blocks, aclk, aresetn, (accept && s_kind == KIND_PRODUCE) |=> !s_ready)
    // the remainder loop stops after one step per integer bit
    `PSPR_ASSERT(a_mod_count, aclk, aresetn, (state_reg == S_MOD) |-> (cnt_reg < CNT_W'(INT_BITS)))
    `PSPR_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> (!m_valid_reg && state_reg == S_IDLE))

endmodule

/* hw/rtl/pspr_datapath.sv */
module pspr_datapath import pspr_pkg::*; #(
    parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [FRAME_W-1:0]         s_load_frame,
    input  logic                       s_load_channel,
    input  logic signed [SAMPLE_W-1:0] s_load_value,
    input  logic [POS_BITS-1:0]        s_seek_position,
    output logic signed [SAMPLE_W-1:0] m_out_left,
    output logic signed [SAMPLE_W-1:0] m_out_right,
    output logic [STATUS_W-1:0]        m_play_status
);

    localparam int MEM_WORDS = MAX_FRAMES * MAX_CHANNELS;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int FIDX_W    = INT_BITS + 1;
    localparam int LAST_W    = FCNT_W + FRAC_BITS;
    localparam int SUM_W     = POS_BITS + 1;
    localparam int NUM_W     = SAMPLE_W + FRAC_BITS + 2;
    localparam int MAG_W     = SAMPLE_W + FRAC_BITS;
    localparam int PROD_W    = MAG_W + 2 * GAIN_W;
    localparam int SHIFT     = FRAC_BITS + 2 * GAIN_FRAC;
    localparam int Q_W       = PROD_W - SHIFT;
    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(1 << (SAMPLE_W - 1));

    logic [SAMPLE_W-1:0] mem [MEM_WORDS];

    logic [POS_BITS-1:0]        pos_reg;
    logic [INT_BITS-1:0]        sh_reg;
    logic [FCNT_W-1:0]          rem_reg;
    logic [SAMPLE_W-1:0]        rdata_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic [2*GAIN_W-1:0]        gain_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        res_left_reg, res_right_reg;
    logic [SAMPLE_W-1:0]        out_left_reg, out_right_reg;
    logic [STATUS_W-1:0]        status_reg;

    logic [INT_BITS-1:0]        lo_f;
    logic [FRAC_BITS-1:0]       frac_eff;
    logic [FIDX_W-1:0]          hi_f, rd_frame;
    logic [ADDR_W-1:0]          rd_addr, ld_addr;
    logic                       ld_ok;
    logic [LAST_W-1:0]          last_pos;
    logic [FCNT_W:0]            mod_try, mod_sub;
    logic                       mod_ge;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [NUM_W-1:0]    interp_prod, num_next;
    logic [2*GAIN_W-1:0]        gain_next;
    logic                       neg;
    logic [NUM_W-1:0]           mag_full;
    logic [MAG_W-1:0]           mag;
    logic [Q_W-1:0]             q;
    logic [SAMPLE_W-1:0]        sat_val;
    logic [SUM_W-1:0]           adv_sum;

    assign lo_f     = pos_reg[POS_BITS-1:FRAC_BITS];
    assign frac_eff = cfg.pitch_unity ? '0 : pos_reg[FRAC_BITS-1:0];
    assign hi_f     = {1'b0, lo_f} + FIDX_W'(frac_eff != '0);
    assign rd_frame = cmd.rd_hi ? hi_f : {1'b0, lo_f};
    assign rd_addr  = ADDR_W'(32'(rd_frame) * MAX_CHANNELS + 32'(cmd.chan));

    assign ld_ok   = (32'(s_load_frame) < MAX_FRAMES) && (32'(s_load_channel) < MAX_CHANNELS);
    assign ld_addr = ADDR_W'(32'(s_load_frame) * MAX_CHANNELS + 32'(s_load_channel));

    assign last_pos    = {cfg.last_frame, {FRAC_BITS{1'b0}}};
    assign sts.at_end  = LAST_W'(pos_reg) >= last_pos;
    assign sts.mute    = (cfg.master_gain == '0);
    assign sts.loop_en = cfg.loop_en;
    assign sts.stereo  = cfg.stereo;

    // one restoring remainder step per integer bit of the position
    assign mod_try = {rem_reg, sh_reg[INT_BITS-1]};
    assign mod_ge  = mod_try >= {1'b0, cfg.last_frame};
    assign mod_sub = mod_try - {1'b0, cfg.last_frame};

    // lo * 2^F + frac * (hi - lo)
    assign diff        = {rdata_reg[SAMPLE_W-1], rdata_reg} - {lo_reg[SAMPLE_W-1], lo_reg};
    assign interp_prod = $signed({1'b0, frac_eff}) * diff;
    assign num_next    = (NUM_W'(lo_reg) <<< FRAC_BITS) + interp_prod;
    assign gain_next   = (cmd.chan ? cfg.right_gain : cfg.left_gain) * cfg.master_gain;

    assign neg      = num_reg[NUM_W-1];
    assign mag_full = neg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign mag      = mag_full[MAG_W-1:0];

    assign q = prod_reg[PROD_W-1:SHIFT];

    // truncate toward zero then clip to the sample range
    always_comb begin
        if (neg_reg) begin
            sat_val = (q > Q_NEG_LIM) ? SAMPLE_MIN : ('0 - q[SAMPLE_W-1:0]);
        end else begin
            sat_val = (q > Q_POS_LIM) ? SAMPLE_MAX : q[SAMPLE_W-1:0];
        end
    end

    assign adv_sum = {1'b0, pos_reg} + SUM_W'(cfg.pitch_step);

    always_ff @(posedge aclk) begin
        if (cmd.load_we && ld_ok) begin
            mem[ld_addr] <= s_load_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.seek) begin
            pos_reg <= s_seek_position;
        end else if (cmd.mod_wb) begin
            pos_reg <= {rem_reg[INT_BITS-1:0], pos_reg[FRAC_BITS-1:0]};
        end else if (cmd.advance) begin
            pos_reg <= adv_sum[POS_BITS] ? '1 : adv_sum[POS_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            rem_reg <= '0;
            sh_reg  <= lo_f;
        end else if (cmd.mod_step) begin
            rem_reg <= mod_ge ? mod_sub[FCNT_W-1:0] : mod_try[FCNT_W-1:0];
            sh_reg  <= sh_reg << 1;
        end
        if (cmd.lo_cap) begin
            lo_reg <= $signed(rdata_reg);
        end
        if (cmd.interp) begin
            num_reg  <= num_next;
            gain_reg <= gain_next;
        end
        if (cmd.scale) begin
            prod_reg <= mag * gain_reg;
            neg_reg  <= neg;
        end
        if (cmd.res_clear) begin
            res_left_reg  <= '0;
            res_right_reg <= '0;
        end else if (cmd.sat) begin
            if (cmd.chan) begin
                res_right_reg <= sat_val;
            end else begin
                res_left_reg <= sat_val;
            end
        end
        if (cmd.out_load) begin
            out_left_reg  <= res_left_reg;
            out_right_reg <= res_right_reg;
            status_reg    <= cmd.status;
        end
    end

    assign m_out_left    = $signed(out_left_reg);
    assign m_out_right   = $signed(out_right_reg);
    assign m_play_status = status_reg;

endmodule

/* bench/pcm_sample_player_resampler_checker.sv */
`timescale 1ns / 1ps

module pcm_sample_player_resampler_checker import pspr_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic [FRAME_W-1:0]         s_load_frame,
    input  logic                       s_load_channel,
    input  logic signed [SAMPLE_W-1:0] s_load_value,
    input  logic [POS_BITS-1:0]        s_seek_position,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_out_left,
    input  logic signed [SAMPLE_W-1:0] m_out_right,
    input  logic [STATUS_W-1:0]        m_play_status,
    output int                         frames_owed,
    output int                         mismatches
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [STATUS_W-1:0]        status;
    } out_frame_t;

    // mirror of the player state
    logic [SAMPLE_W-1:0] clip [0:MAX_FRAMES_DEF*MAX_CHANNELS_DEF-1];
    logic [POS_BITS-1:0] position;
    logic                loop_on;
    logic [CHCNT_W-1:0]  chan_sel;
    logic [FCNT_W-1:0]   frame_sel;
    logic [STEP_W-1:0]   step;
    logic [GAIN_W-1:0]   master;
    logic [GAIN_W-1:0]   lgain;
    logic [GAIN_W-1:0]   rgain;

    out_frame_t expected_frames[$];

    function automatic longint clip_sample(int frame, int ch);
        return longint'($signed(clip[frame * MAX_CHANNELS_DEF + ch]));
    endfunction

    // exact num * gain / 2^44, truncated toward zero, then clamped to int16
    function automatic logic [SAMPLE_W-1:0] apply_gain(longint num, logic [31:0] g);
        logic [71:0] mag;
        logic [71:0] q;
        mag = (num < 0) ? 72'(-num) : 72'(num);
        q = (mag * 72'(g)) >> (FRAC_BITS + 2 * GAIN_FRAC);
        if (num < 0) begin
            if (q > 72'd32768) q = 72'd32768;
            return SAMPLE_W'(~q + 72'd1);
        end else begin
            if (q > 72'd32767) q = 72'd32767;
            return SAMPLE_W'(q);
        end
    endfunction

    // one output frame; moves the play position as the player does
    function automatic out_frame_t play_frame();
        out_frame_t          res;
        int                  chans;
        int                  frames;
        int                  lo_f;
        int                  hi_f;
        logic [POS_BITS-1:0] last_pos;
        logic [POS_BITS:0]   sum;
        logic [31:0]         g;
        longint              frac;
        longint              lo;
        longint              hi;
        res = '0;
        if (master == '0) begin
            res.status = ST_MUTED;
            return res;
        end
        chans = (chan_sel == 0) ? 1 : (chan_sel > 2) ? 2 : int'(chan_sel);
        frames = (frame_sel < 2) ? 2 : (frame_sel > 4096) ? 4096 : int'(frame_sel);
        last_pos = POS_BITS'(frames - 1) << FRAC_BITS;
        if (position >= last_pos) begin
            if (loop_on) begin
                position = position % last_pos;
            end else begin
                res.status = ST_ENDED;
                return res;
            end
        end
        lo_f = int'(position[POS_BITS-1:FRAC_BITS]);
        frac = longint'(position[FRAC_BITS-1:0]);
        if (step == STEP_ONE) frac = 0;
        hi_f = (frac != 0) ? lo_f + 1 : lo_f;
        for (int c = 0; c < chans; c++) begin
            lo = clip_sample(lo_f, c);
            hi = clip_sample(hi_f, c);
            g = 32'(c == 0 ? lgain : rgain) * 32'(master);
            if (c == 0) res.left = apply_gain(lo * 65536 + frac * (hi - lo), g);
            else res.right = apply_gain(lo * 65536 + frac * (hi - lo), g);
        end
        res.status = ST_PLAYING;
        sum = {1'b0, position} + (POS_BITS + 1)'(step);
        position = sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_frame_t exp_frame;
        int         fresh_errors;
        int         pushed;
        int         popped;
        fresh_errors = 0;
        pushed = 0;
        popped = 0;
        if (!aresetn) begin
            position = '0;
            loop_on = 1'b0;
            chan_sel = RST_CHCNT;
            frame_sel = RST_FCNT;
            step = STEP_ONE;
            master = GAIN_ONE;
            lgain = GAIN_ONE;
            rgain = GAIN_ONE;
            expected_frames.delete();
            frames_owed <= 0;
            mismatches <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOOP:   loop_on = cfg_wdata[0];
                    CFG_CHCNT:  chan_sel = cfg_wdata[CHCNT_W-1:0];
                    CFG_FCNT:   frame_sel = cfg_wdata[FCNT_W-1:0];
                    CFG_STEP:   step = cfg_wdata[STEP_W-1:0];
                    CFG_MASTER: master = cfg_wdata[GAIN_W-1:0];
                    CFG_LGAIN:  lgain = cfg_wdata[GAIN_W-1:0];
                    CFG_RGAIN:  rgain = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_kind)
                    KIND_LOAD:    clip[{s_load_frame, s_load_channel}] = s_load_value;
                    KIND_SEEK:    position = s_seek_position;
                    KIND_PRODUCE: begin
                        expected_frames.push_back(play_frame());
                        pushed = 1;
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("output frame with none expected: left %0d right %0d status %0d",
                           m_out_left, m_out_right, m_play_status);
                    fresh_errors++;
                end else begin
                    exp_frame = expected_frames.pop_front();
                    popped = 1;
                    if (m_out_left !== exp_frame.left) begin
                        $error("out_left expected %0d got %0d",
                               $signed(exp_frame.left), m_out_left);
                        fresh_errors++;
                    end
                    if (m_out_right !== exp_frame.right) begin
                        $error("out_right expected %0d got %0d",
                               $signed(exp_frame.right), m_out_right);
                        fresh_errors++;
                    end
                    if (m_play_status !== exp_frame.status) begin
                        $error("play_status expected %0d got %0d",
                               exp_frame.status, m_play_status);
                        fresh_errors++;
                    end
                end
            end
            frames_owed <= frames_owed + pushed - popped;
            mismatches <= mismatches + fresh_errors;
        end
    end

endmodule

/* bench/pcm_sample_player_resampler_top_test.sv */
`timescale 1ns / 1ps

module pcm_sample_player_resampler_top_test;
    import pspr_pkg::*;

    // the kind code the player has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // frames loaded at the start of the clip; the last two frames are loaded too
    localparam int FILL_FRAMES = 64;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [KIND_W-1:0]          s_kind = KIND_LOAD;
    logic [FRAME_W-1:0]         s_load_frame = '0;
    logic                       s_load_channel = 1'b0;
    logic signed [SAMPLE_W-1:0] s_load_value = '0;
    logic [POS_BITS-1:0]        s_seek_position = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_left;
    logic signed [SAMPLE_W-1:0] m_out_right;
    logic [STATUS_W-1:0]        m_play_status;

    int frames_owed;
    int mismatches;

    // when set, neither side idles any more
    bit calm = 1'b0;
    int sink_stall = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pcm_sample_player_resampler_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_load_frame    (s_load_frame),
        .s_load_channel  (s_load_channel),
        .s_load_value    (s_load_value),
        .s_seek_position (s_seek_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_play_status   (m_play_status)
    );

    pcm_sample_player_resampler_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_load_frame    (s_load_frame),
        .s_load_channel  (s_load_channel),
        .s_load_value    (s_load_value),
        .s_seek_position (s_seek_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_play_status   (m_play_status),
        .frames_owed     (frames_owed),
        .mismatches      (mismatches)
    );

    // output side: ready drops now and then for a random burst
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one input transfer, sometimes after a random idle; valid holds with the payload until taken
    task automatic send(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] frame,
                        input logic ch, input logic [SAMPLE_W-1:0] value,
                        input logic [POS_BITS-1:0] pos);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_load_frame <= frame;
        s_load_channel <= ch;
        s_load_value <= value;
        s_seek_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    // unused fields of produce and seek items carry noise
    task automatic produce();
        send(KIND_PRODUCE, FRAME_W'($urandom), 1'($urandom), SAMPLE_W'($urandom),
             POS_BITS'($urandom));
    endtask

    task automatic seek(input logic [POS_BITS-1:0] pos);
        send(KIND_SEEK, FRAME_W'($urandom), 1'($urandom), SAMPLE_W'($urandom), pos);
    endtask

    // stop sending, let every frame come out, then give the sequencer time to settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_owed != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // registers change only once the player has gone quiet
    task automatic reconfigure(input logic loop_en, input logic [CHCNT_W-1:0] chans,
                               input logic [FCNT_W-1:0] frames, input logic [STEP_W-1:0] stp,
                               input logic [GAIN_W-1:0] mg, input logic [GAIN_W-1:0] lg,
                               input logic [GAIN_W-1:0] rg);
        drain();
        write_reg(CFG_LOOP, CFG_DATA_W'(loop_en));
        write_reg(CFG_CHCNT, CFG_DATA_W'(chans));
        write_reg(CFG_FCNT, CFG_DATA_W'(frames));
        write_reg(CFG_STEP, CFG_DATA_W'(stp));
        write_reg(CFG_MASTER, CFG_DATA_W'(mg));
        write_reg(CFG_LGAIN, CFG_DATA_W'(lg));
        write_reg(CFG_RGAIN, CFG_DATA_W'(rg));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_ONE;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // mostly somewhere inside the clip, now and then anywhere at all
    function automatic logic [POS_BITS-1:0] pick_position(int frames);
        if ($urandom_range(0, 9) == 0) return POS_BITS'($urandom);
        return POS_BITS'($urandom_range(0, frames * 65536 - 1));
    endfunction

    initial begin
        logic [FCNT_W-1:0] fc_pick;
        logic [STEP_W-1:0] step_pick;
        int                eff_frames;
        int                roll;
        int                fr;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the first frames and the last two so no read ever lands on an
        // unwritten word; frames 0 and 1 hold the sample extremes
        for (int i = 0; i < FILL_FRAMES + 2; i++) begin
            fr = (i < FILL_FRAMES) ? i : MAX_FRAMES_DEF - FILL_FRAMES - 2 + i;
            for (int ch = 0; ch < MAX_CHANNELS_DEF; ch++) begin
                send(KIND_LOAD, FRAME_W'(fr), 1'(ch),
                     (fr < 2) ? (((fr + ch) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN)
                              : SAMPLE_W'($urandom),
                     POS_BITS'($urandom));
            end
        end

        // defaults: stereo, unity step, position zero
        produce();
        seek(28'h000_8000);
        produce();

        // half step, interpolating across the full sample swing
        reconfigure(1'b0, 2'd2, 13'd8, 24'h00_8000, GAIN_ONE, GAIN_ONE, GAIN_ONE);
        seek(28'h000_4000);
        produce();
        produce();

        // mono at full gains, saturating both ways
        reconfigure(1'b1, 2'd1, 13'd8, 24'h01_8000, '1, '1, '1);
        seek('0);
        produce();
        produce();

        // master gain zero mutes
        reconfigure(1'b0, 2'd2, 13'd8, STEP_ONE, '0, GAIN_ONE, GAIN_ONE);
        produce();

        // seek past the end, then stop without looping
        reconfigure(1'b0, 2'd2, 13'd8, STEP_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE);
        seek('1);
        produce();

        // same spot with looping on wraps instead
        reconfigure(1'b1, 2'd2, 13'd8, STEP_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE);
        produce();

        // largest step from near the end overflows the position, then wraps
        reconfigure(1'b1, 2'd3, 13'd4096, '1, GAIN_ONE, '1, 16'd1);
        seek(28'h0FFE_0000);
        produce();
        produce();

        // channel count zero, frame count clamped up to two, step zero
        reconfigure(1'b1, 2'd0, 13'd0, '0, GAIN_ONE, 16'd12345, GAIN_ONE);
        seek(28'h000_C000);
        produce();
        produce();

        // frame count clamped down, tiny step walks onto the last frame
        reconfigure(1'b0, 2'd2, '1, 24'd1, GAIN_ONE, GAIN_ONE, GAIN_ONE);
        seek(28'h0FFE_FFFF);
        produce();
        produce();

        // the spare kind is dropped
        send(KIND_UNUSED, FRAME_W'($urandom), 1'($urandom), SAMPLE_W'($urandom),
             POS_BITS'($urandom));
        produce();

        // random phases: fresh settings, a seek, then a mixed run of items
        for (int phase = 0; phase < 32; phase++) begin
            if (phase == 28) calm = 1'b1;
            // frame counts stay within the filled frames
            case ($urandom_range(0, 9))
                0:       fc_pick = FCNT_W'($urandom_range(0, 1));
                1:       fc_pick = FCNT_W'(FILL_FRAMES);
                2:       fc_pick = FCNT_W'($urandom_range(2, FILL_FRAMES));
                default: fc_pick = FCNT_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 7))
                0, 1:    step_pick = STEP_ONE;
                2:       step_pick = '0;
                3:       step_pick = STEP_W'($urandom);
                4:       step_pick = STEP_W'($urandom_range(1, 65535));
                default: step_pick = STEP_W'($urandom_range(65537, 4 * 65536));
            endcase
            reconfigure(1'($urandom), CHCNT_W'($urandom_range(0, 3)), fc_pick, step_pick,
                        pick_gain(), pick_gain(), pick_gain());
            eff_frames = (fc_pick < 2) ? 2 : (fc_pick > 4096) ? 4096 : int'(fc_pick);
            seek(pick_position(eff_frames));
            for (int n = 0; n < 42; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    produce();
                end else if (roll < 82) begin
                    send(KIND_LOAD, FRAME_W'($urandom_range(0, eff_frames - 1)),
                         1'($urandom), SAMPLE_W'($urandom), POS_BITS'($urandom));
                end else if (roll < 94) begin
                    seek(pick_position(eff_frames));
                end else begin
                    send(KIND_UNUSED, FRAME_W'($urandom), 1'($urandom),
                         SAMPLE_W'($urandom), POS_BITS'($urandom));
                end
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hung handshake guard
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
